// File: design/positional_list_insert_delete_assert.svh
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// check a property outside of reset
`define PLI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// check a property on every clock edge, reset included
`define PLI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/pli_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Field widths, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int PLI_CAPACITY = 16;
   localparam int MODE_W       = 2;
   localparam int POS_W        = 8;
   localparam int VAL_W        = 8;
   localparam int STAT_W       = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_DISPLAY = 2'd0,
      MODE_INSERT  = 2'd1,
      MODE_DELETE  = 2'd2
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_BOUNDS  = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ROTATE = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   index;
      logic [VAL_W-1:0]   value;
   } dp_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]   length;
      logic [VAL_W-1:0]   head;
   } dp_stat_type;

endpackage

// File: design/pli_if.sv
// ----------------------------------------------------------------------------
// Positional list channel interfaces
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface pli_req_if import pli_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [POS_W-1:0]   position;
   logic [VAL_W-1:0]   item_value;

   modport source (output valid, output mode, output position, output item_value,
                   input ready);
   modport sink   (input valid, input mode, input position, input item_value,
                   output ready);
endinterface

interface pli_rsp_if import pli_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [VAL_W-1:0]   entry_value;
   logic               last;

   modport source (output valid, output status, output entry_value, output last,
                   input ready);
   modport sink   (input valid, input status, input entry_value, input last,
                   output ready);
endinterface

// File: design/pli_datapath.sv
// ----------------------------------------------------------------------------
// Positional list datapath
// Shifting entry array and length register; insert, delete, rotate.
// ----------------------------------------------------------------------------
module pli_datapath
   import pli_pkg::*;
#(
   parameter int CAPACITY = PLI_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat
);

   localparam int LEN_W = $clog2(CAPACITY + 1);

   logic [VAL_W-1:0] entries_ff [CAPACITY];
   logic [VAL_W-1:0] entries_in [CAPACITY];
   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] length_in;
   logic [POS_W-1:0] len_p;
   logic [POS_W-1:0] len_m1;

   assign len_p  = POS_W'(length_ff);
   assign len_m1 = len_p - POS_W'(1);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] prev_v;
      logic [VAL_W-1:0] next_v;
      logic [POS_W-1:0] pos_i;

      assign pos_i = POS_W'(i);

      if (i > 0) begin : g_prev
         assign prev_v = entries_ff[i-1];
      end else begin : g_noprev
         assign prev_v = entries_ff[0];
      end

      if (i < CAPACITY - 1) begin : g_next
         assign next_v = entries_ff[i+1];
      end else begin : g_nonext
         assign next_v = entries_ff[i];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         case (cmd.op)
            OP_INSERT: begin
               if (pos_i == cmd.index) begin
                  entries_in[i] = cmd.value;
               end else if (pos_i > cmd.index && pos_i <= len_p) begin
                  entries_in[i] = prev_v;
               end
            end
            OP_DELETE: begin
               if (pos_i >= cmd.index && pos_i < len_m1) begin
                  entries_in[i] = next_v;
               end
            end
            OP_ROTATE: begin
               if (pos_i < len_m1) begin
                  entries_in[i] = next_v;
               end else if (pos_i == len_m1) begin
                  entries_in[i] = entries_ff[0];
               end
            end
            default: begin
               entries_in[i] = entries_ff[i];
            end
         endcase
      end
   end

   always_comb begin
      case (cmd.op)
         OP_INSERT: length_in = length_ff + LEN_W'(1);
         OP_DELETE: length_in = length_ff - LEN_W'(1);
         default:   length_in = length_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   assign stat.length = len_p;
   assign stat.head   = entries_ff[0];

endmodule

// File: design/pli_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list controller
// Request decode, error checks, display sequencing and response register.
// ----------------------------------------------------------------------------
module pli_ctrl
   import pli_pkg::*;
#(
   parameter int CAPACITY = PLI_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   pli_req_if.sink     req_chan,
   pli_rsp_if.source   rsp_chan,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic {
      S_IDLE,
      S_DISP
   } state_type;

   state_type         state_ff,   state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff,  status_in;
   logic [VAL_W-1:0]  value_ff,   value_in;
   logic              last_ff,    last_in;
   logic [POS_W-1:0]  remain_ff,  remain_in;

   logic              slot_free;
   logic              accept;
   logic [POS_W:0]    pos_x;
   logic [POS_W:0]    len_x;
   logic              is_empty;
   logic              is_full;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !reset && (state_ff == S_IDLE) && slot_free;
   assign accept   = req_chan.valid && req_chan.ready;
   assign pos_x    = {1'b0, req_chan.position};
   assign len_x    = {1'b0, stat.length};
   assign is_empty = (stat.length == '0);
   assign is_full  = (stat.length == POS_W'(CAPACITY));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      remain_in    = remain_ff;
      cmd.op       = OP_NONE;
      cmd.index    = req_chan.position - POS_W'(1);
      cmd.value    = req_chan.item_value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = '0;
               last_in  = 1'b1;
               case (mode_type'(req_chan.mode))
                  MODE_DISPLAY: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_EMPTY;
                     end else begin
                        state_in  = S_DISP;
                        remain_in = stat.length;
                     end
                  end
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (req_chan.position == '0) begin
                        status_in = ST_INVALID;
                     end else if (pos_x > len_x + (POS_W+1)'(1)) begin
                        status_in = ST_BOUNDS;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        cmd.op    = OP_INSERT;
                     end
                  end
                  MODE_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (req_chan.position == '0) begin
                        status_in = ST_INVALID;
                     end else if (pos_x > len_x) begin
                        status_in = ST_BOUNDS;
                     end else begin
                        status_in = ST_OK;
                        cmd.op    = OP_DELETE;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                  end
               endcase
            end
         end
         S_DISP: begin
            cmd.index = '0;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               value_in     = stat.head;
               last_in      = (remain_ff == POS_W'(1));
               cmd.op       = OP_ROTATE;
               remain_in    = remain_ff - POS_W'(1);
               if (remain_ff == POS_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_value = value_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// File: design/positional_list_insert_delete.sv
// Insert, delete and error responses are registered in the cycle after the request
// transaction; the first display entry passes the controller state register and then
// the response register. Insert and delete requests can be accepted back to back while
// responses are not stalled; display rotates the entry array once per emitted entry.
// Reset: synchronous; clears the length, the controller state and the response valid,
// and holds the request ready low.
// ----------------------------------------------------------------------------
// Positional insert/delete list
// Ordered byte list with 1-based insert, delete and display operations.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
   import pli_pkg::*;
#(
   parameter int CAPACITY = PLI_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   pli_req_if.sink    req_chan,
   pli_rsp_if.source  rsp_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pli_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

   pli_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

// File: design/pli_checker.sv
// ----------------------------------------------------------------------------
// Positional list checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_assert.svh"

module pli_checker
   import pli_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [STAT_W-1:0] rsp_status,
   input logic [VAL_W-1:0]  rsp_entry_value,
   input logic              rsp_last
);

   property p_no_rsp_after_reset;
      $past(reset) |-> !rsp_valid;
   endproperty

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_value) && $stable(rsp_last);
   endproperty

   property p_error_single;
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_entry_value == '0;
   endproperty

   property p_status_range;
      rsp_valid |-> rsp_status <= ST_FULL;
   endproperty

   `PLI_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, p_no_rsp_after_reset, "response after reset")

   `PLI_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled response changed")

   `PLI_ASSERT(a_error_single, clock, reset, p_error_single, "error response not single zero")

   `PLI_ASSERT(a_status_range, clock, reset, p_status_range, "undefined status code")

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_value (rsp_chan.entry_value),
   .rsp_last        (rsp_chan.last)
);
